// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition leads to another one on the next clk edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ces_pkg.sv =====
// ----------------------------------------------------------------------------
// Contactor economizer supervisor package
// Shared types and codes for the coil state, the command beat and settings.
// ----------------------------------------------------------------------------
package ces_pkg;

    // Full pull-in compare value, saturated to the 4 bit duty field
    localparam int FULL_DUTY     = 10;
    localparam int FULL_DUTY_CAP = (FULL_DUTY > 15) ? 15 : FULL_DUTY;

    // Commands
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_ON        = 2'd1;
    localparam logic [1:0] CMD_OFF       = 2'd2;
    localparam logic [1:0] CMD_SUPERVISE = 2'd3;

    // Coil modes
    localparam logic [1:0] COIL_OFF    = 2'd0;
    localparam logic [1:0] COIL_PULLIN = 2'd1;
    localparam logic [1:0] COIL_ECON   = 2'd2;

    // Charge modes
    localparam logic [1:0] MODE_ALL_ON  = 2'd0;
    localparam logic [1:0] MODE_TWO_ON  = 2'd1;
    localparam logic [1:0] MODE_ALL_OFF = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_SOC_HIGH   = 3'd0;
    localparam logic [2:0] REG_SOC_MID    = 3'd1;
    localparam logic [2:0] REG_SOC_LOW    = 3'd2;
    localparam logic [2:0] REG_SOC_HYST   = 3'd3;
    localparam logic [2:0] REG_TEMP_LIMIT = 3'd4;
    localparam logic [2:0] REG_TEMP_HYST  = 3'd5;
    localparam logic [2:0] REG_PULLIN     = 3'd6;
    localparam logic [2:0] REG_ECON_DUTY  = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] cnt;
        logic [3:0] duty;
    } coil_t;

    typedef struct packed {
        coil_t [3:0] coil;
        logic [1:0]  charge_mode;
    } state_t;

    typedef struct packed {
        logic [13:0]        soc_high;
        logic [13:0]        soc_mid;
        logic [13:0]        soc_low;
        logic [9:0]         soc_hysteresis;
        logic signed [11:0] temp_limit;
        logic [8:0]         temp_hysteresis;
        logic [7:0]         pullin_ticks;
        logic [3:0]         economy_duty;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         contactor_index;
        logic [13:0]        soc;
        logic signed [11:0] temp_one;
        logic signed [11:0] temp_two;
        logic signed [11:0] temp_three;
    } item_t;

endpackage

// ===== rtl/ces_step.sv =====
// ----------------------------------------------------------------------------
// Contactor economizer step
// Next coil and charge state for one command beat, all in one combinational pass.
// ----------------------------------------------------------------------------
module ces_step (
    input  ces_pkg::cfg_t   cfg,
    input  ces_pkg::item_t  item,
    input  ces_pkg::state_t state,
    output ces_pkg::state_t state_next
);
    import ces_pkg::*;

    coil_t [3:0]        c;
    logic [1:0]         m;
    logic signed [11:0] tv [3];
    logic signed [11:0] ts [3];
    logic [1:0]         us [3];
    logic signed [11:0] t_tmp;
    logic [1:0]         u_tmp;
    logic [1:0]         n_on;
    logic [1:0]         chosen;
    logic signed [13:0] hyst_t;
    logic signed [13:0] hot;
    logic signed [13:0] thr;
    logic signed [13:0] gap;
    logic signed [15:0] soc_s;
    logic signed [15:0] hyst_s;

    function automatic coil_t coil_on(coil_t c_in);
        coil_t r;
        r = c_in;
        if (c_in.mode == COIL_OFF)
        begin
            r.duty = 4'(FULL_DUTY_CAP);
            r.mode = COIL_PULLIN;
            r.cnt  = '0;
        end
        return r;
    endfunction

    function automatic coil_t coil_off(coil_t c_in);
        coil_t r;
        r      = c_in;
        r.duty = '0;
        r.mode = COIL_OFF;
        return r;
    endfunction

    assign tv[0] = item.temp_one;
    assign tv[1] = item.temp_two;
    assign tv[2] = item.temp_three;

    // Apply the command to the coils and the charge machine
    always_comb
    begin
        c      = state.coil;
        m      = state.charge_mode;
        n_on   = '0;
        chosen = '0;
        t_tmp  = '0;
        u_tmp  = '0;
        for (int i = 0; i < 3; i++)
        begin
            ts[i] = tv[i];
            us[i] = 2'(i);
        end
        hyst_t = $signed({5'b0, cfg.temp_hysteresis});
        hot    = 14'(cfg.temp_limit) + hyst_t;
        thr    = 14'(cfg.temp_limit) - hyst_t;
        gap    = '0;
        soc_s  = $signed({2'b0, item.soc});
        hyst_s = $signed({6'b0, cfg.soc_hysteresis});

        unique case (item.cmd)
            CMD_TICK:
            begin
                // Count pull-in, then drop to economizer duty
                for (int i = 0; i < 4; i++)
                begin
                    if (c[i].mode == COIL_PULLIN)
                    begin
                        if (c[i].cnt != 8'hFF)
                            c[i].cnt = c[i].cnt + 8'd1;
                        if (c[i].cnt >= cfg.pullin_ticks)
                        begin
                            c[i].duty = cfg.economy_duty;
                            c[i].mode = COIL_ECON;
                        end
                    end
                end
            end
            CMD_ON:
                c[item.contactor_index] = coil_on(c[item.contactor_index]);
            CMD_OFF:
                c[item.contactor_index] = coil_off(c[item.contactor_index]);
            CMD_SUPERVISE:
            begin
                // Drop overheated inputs first
                for (int i = 0; i < 3; i++)
                    if (14'(tv[i]) > hot)
                        c[i] = coil_off(c[i]);

                // Charge hysteresis machine
                if (soc_s > $signed({2'b0, cfg.soc_high}))
                    m = MODE_ALL_OFF;
                else if (soc_s < $signed({2'b0, cfg.soc_mid}) - hyst_s
                         && m == MODE_ALL_OFF)
                    m = MODE_TWO_ON;
                else if (soc_s < $signed({2'b0, cfg.soc_low}) - hyst_s
                         && m == MODE_TWO_ON)
                    m = MODE_ALL_ON;
                else if (soc_s > $signed({2'b0, cfg.soc_mid}) + hyst_s
                         && m == MODE_TWO_ON)
                    m = MODE_ALL_OFF;

                case (m)
                    MODE_ALL_ON:
                        for (int i = 0; i < 3; i++)
                            c[i] = coil_on(c[i]);
                    MODE_ALL_OFF:
                        for (int i = 0; i < 3; i++)
                            c[i] = coil_off(c[i]);
                    MODE_TWO_ON:
                    begin
                        for (int i = 0; i < 3; i++)
                            if (c[i].mode != COIL_OFF)
                                n_on = n_on + 2'd1;
                        // Exchange sort, coolest first; ties need not keep unit order
                        for (int i = 0; i < 2; i++)
                        begin
                            for (int j = i + 1; j < 3; j++)
                            begin
                                if (ts[i] > ts[j])
                                begin
                                    t_tmp = ts[i];
                                    u_tmp = us[i];
                                    ts[i] = ts[j];
                                    us[i] = us[j];
                                    ts[j] = t_tmp;
                                    us[j] = u_tmp;
                                end
                            end
                        end
                        gap = 14'(ts[2]) - 14'(ts[1]);
                        if (n_on == 2'd3 || (n_on == 2'd2 && gap > hyst_t))
                        begin
                            // Keep up to two cool units on, shed the hottest
                            for (int i = 0; i < 3; i++)
                            begin
                                if (chosen < 2'd2 && 14'(ts[i]) < thr)
                                begin
                                    c[us[i]] = coil_on(c[us[i]]);
                                    chosen   = chosen + 2'd1;
                                end
                            end
                            c[us[2]] = coil_off(c[us[2]]);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        state_next.coil        = c;
        state_next.charge_mode = m;
    end

endmodule

// ===== rtl/contactor_economizer_supervisor.sv =====
// ----------------------------------------------------------------------------
// Contactor economizer supervisor
// Coil PWM compare values for three input contactors and one output contactor.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on s_axis (cmd in tuser: tick, on, off, supervise).
//   Every command beat yields exactly one status beat on m_axis carrying the
//   four coil compare values, the charge mode and the on and economized masks
//   after that command took effect.
//   A command beat passes through the input register, then through the step
//   logic into the output register.
//   Throughput is one beat per cycle while m_axis does not stall; the only loop
//   is the coil and charge state register fed back through the step logic.
//   When m_axis stalls the output register holds its beat and the input
//   register still takes one more beat; s_axis_tready falls only when both
//   are full.
//   Settings are written on the cfg channel (cfg_ready is always high) and
//   act on the next command processed.
//   Reset clears all coils to off with zero duty, selects the all-on charge
//   mode, loads the default settings and empties both registers.
// ----------------------------------------------------------------------------
module contactor_economizer_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // settings write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    // command beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // contactor_index, soc, temp_one, temp_two,
                                       // temp_three, zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd
    // status beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // duty_zero, duty_one, duty_two, duty_three,
                                       // charge_mode, on_mask, economized_mask,
                                       // zero fill
);
    import ces_pkg::*;

    `include "assert_macros.svh"

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    state_t      state_reg;
    state_t      state_next;
    logic [25:0] out_reg;
    logic [25:0] out_next;
    logic        out_valid_reg;
    logic        advance;
    logic        in_accept;
    logic [3:0]  on_mask;
    logic [3:0]  eco_mask;

    assign cfg_ready     = 1'b1;
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.soc_high        <= 14'd9900;
            cfg_reg.soc_mid         <= 14'd9800;
            cfg_reg.soc_low         <= 14'd9700;
            cfg_reg.soc_hysteresis  <= 10'd50;
            cfg_reg.temp_limit      <= 12'sd600;
            cfg_reg.temp_hysteresis <= 9'd50;
            cfg_reg.pullin_ticks    <= 8'd10;
            cfg_reg.economy_duty    <= 4'd5;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SOC_HIGH:   cfg_reg.soc_high        <= cfg_data;
                REG_SOC_MID:    cfg_reg.soc_mid         <= cfg_data;
                REG_SOC_LOW:    cfg_reg.soc_low         <= cfg_data;
                REG_SOC_HYST:   cfg_reg.soc_hysteresis  <= cfg_data[9:0];
                REG_TEMP_LIMIT: cfg_reg.temp_limit      <= $signed(cfg_data[11:0]);
                REG_TEMP_HYST:  cfg_reg.temp_hysteresis <= cfg_data[8:0];
                REG_PULLIN:     cfg_reg.pullin_ticks    <= cfg_data[7:0];
                REG_ECON_DUTY:  cfg_reg.economy_duty    <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: take a beat whenever it is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_accept)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.cmd             <= s_axis_tuser;
            item_reg.contactor_index <= s_axis_tdata[1:0];
            item_reg.soc             <= s_axis_tdata[15:2];
            item_reg.temp_one        <= $signed(s_axis_tdata[27:16]);
            item_reg.temp_two        <= $signed(s_axis_tdata[39:28]);
            item_reg.temp_three      <= $signed(s_axis_tdata[51:40]);
        end
    end

    ces_step u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next)
    );

    // Status fields from the updated state
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            on_mask[i]  = (state_next.coil[i].mode != COIL_OFF);
            eco_mask[i] = (state_next.coil[i].mode == COIL_ECON);
        end
        out_next = {eco_mask, on_mask, state_next.charge_mode,
                    state_next.coil[3].duty, state_next.coil[2].duty,
                    state_next.coil[1].duty, state_next.coil[0].duty};
    end

    // Coil and charge state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                state_reg.coil[i].mode <= COIL_OFF;
                state_reg.coil[i].cnt  <= '0;
                state_reg.coil[i].duty <= '0;
            end
            state_reg.charge_mode <= MODE_ALL_ON;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg};

    `ASSERT_NEXT(a_item_kept, item_valid_reg && !advance, item_valid_reg,
        "stalled command beat dropped")
    `ASSERT_NEXT(a_result_made, advance, out_valid_reg,
        "processed command gave no status beat")
    `ASSERT_IMPL(a_eco_subset, out_valid_reg, (out_reg[25:22] & ~out_reg[21:18]) == 4'b0,
        "economized contactor reported off")
    `ASSERT_IMPL(a_off_zero, state_reg.coil[0].mode == COIL_OFF,
        state_reg.coil[0].duty == 4'b0, "off coil holds nonzero duty")

endmodule

// ===== tb/contactor_economizer_supervisor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contactor economizer supervisor testbench
// Drives command beats (tick, on, off, supervise) with random idle and stall
// bursts, predicts status beats from a behavioral coil and charge model or a
// directed table, and compares each status beat field by field.
// ----------------------------------------------------------------------------
module contactor_economizer_supervisor_tb;

    import ces_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // Status beat as it appears on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [5:0] fill;
        logic [3:0] eco_mask;
        logic [3:0] on_mask;
        logic [1:0] charge_mode;
        logic [3:0] duty_three;
        logic [3:0] duty_two;
        logic [3:0] duty_one;
        logic [3:0] duty_zero;
    } status_t;

    // One line of the directed table
    typedef struct {
        int         reps;
        logic [1:0] cmd;
        logic [1:0] idx;
        int         soc;
        int         t_one;
        int         t_two;
        int         t_three;
        bit         typed;
        status_t    want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [13:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // contactor_index, soc, temp_one, temp_two,
                                 // temp_three, zero fill
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // duty_zero, duty_one, duty_two, duty_three,
                                 // charge_mode, on_mask, economized_mask, zero fill

    contactor_economizer_supervisor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of coil state, charge mode and settings
    logic [1:0] coil_mode [4];
    logic [7:0] pull_cnt  [4];
    logic [3:0] coil_duty [4];
    logic [1:0] charge_mode_q;
    cfg_t       settings;

    status_t status_due_q [$];
    item_t   cur_item;
    bit      cur_typed;
    status_t cur_want;
    bit      idle_on;
    bit      idle_on_allowed;
    int      stall_left;
    int      mismatch_count;
    int      cycle_count;
    int      beats_sent;

    // ------------------------------------------------------------------
    // Coil and charge machine prediction
    // ------------------------------------------------------------------
    task automatic coil_engage(input int k);
        if (coil_mode[k] == COIL_OFF)
        begin
            coil_duty[k] = 4'(FULL_DUTY_CAP);
            coil_mode[k] = COIL_PULLIN;
            pull_cnt[k]  = 8'd0;
        end
    endtask

    task automatic coil_release(input int k);
        coil_duty[k] = 4'd0;
        coil_mode[k] = COIL_OFF;
    endtask

    // Keep the coolest two units below the limit band, drop the hottest
    task automatic keep_coolest_pair(input int tv [3]);
        int unit [3];
        int t    [3];
        int n_on;
        int chosen;
        int thr;
        int swap_t;
        int swap_u;
        n_on = 0;
        for (int i = 0; i < 3; i++)
        begin
            unit[i] = i;
            t[i]    = tv[i];
            if (coil_mode[i] != COIL_OFF)
                n_on++;
        end
        // exchange sort, ties need not keep unit order
        for (int i = 0; i < 2; i++)
            for (int j = i + 1; j < 3; j++)
                if (t[i] > t[j])
                begin
                    swap_t  = t[i];
                    swap_u  = unit[i];
                    t[i]    = t[j];
                    unit[i] = unit[j];
                    t[j]    = swap_t;
                    unit[j] = swap_u;
                end
        if (n_on == 3 || (n_on == 2 && t[2] - t[1] > int'(settings.temp_hysteresis)))
        begin
            thr    = int'(settings.temp_limit) - int'(settings.temp_hysteresis);
            chosen = 0;
            for (int i = 0; i < 3; i++)
                if (chosen < 2 && t[i] < thr)
                begin
                    coil_engage(unit[i]);
                    chosen++;
                end
            coil_release(unit[2]);
        end
    endtask

    task automatic supervise_pack(input int soc, input int tv [3]);
        int hot;
        int h;
        hot = int'(settings.temp_limit) + int'(settings.temp_hysteresis);
        h   = int'(settings.soc_hysteresis);
        // overheated units drop first
        for (int i = 0; i < 3; i++)
            if (tv[i] > hot)
                coil_release(i);
        // charge hysteresis machine
        if (soc > int'(settings.soc_high))
            charge_mode_q = MODE_ALL_OFF;
        else if (soc < int'(settings.soc_mid) - h && charge_mode_q == MODE_ALL_OFF)
            charge_mode_q = MODE_TWO_ON;
        else if (soc < int'(settings.soc_low) - h && charge_mode_q == MODE_TWO_ON)
            charge_mode_q = MODE_ALL_ON;
        else if (soc > int'(settings.soc_mid) + h && charge_mode_q == MODE_TWO_ON)
            charge_mode_q = MODE_ALL_OFF;
        if (charge_mode_q == MODE_ALL_ON)
            for (int i = 0; i < 3; i++)
                coil_engage(i);
        else if (charge_mode_q == MODE_TWO_ON)
            keep_coolest_pair(tv);
        else if (charge_mode_q == MODE_ALL_OFF)
            for (int i = 0; i < 3; i++)
                coil_release(i);
    endtask

    task automatic advance_pullin();
        for (int i = 0; i < 4; i++)
            if (coil_mode[i] == COIL_PULLIN)
            begin
                if (pull_cnt[i] != 8'hFF)
                    pull_cnt[i] = pull_cnt[i] + 8'd1;
                if (pull_cnt[i] >= settings.pullin_ticks)
                begin
                    coil_duty[i] = settings.economy_duty;
                    coil_mode[i] = COIL_ECON;
                end
            end
    endtask

    task automatic apply_command(input item_t it);
        int tv [3];
        tv[0] = int'(it.temp_one);
        tv[1] = int'(it.temp_two);
        tv[2] = int'(it.temp_three);
        case (it.cmd)
            CMD_TICK:  advance_pullin();
            CMD_ON:    coil_engage(int'(it.contactor_index));
            CMD_OFF:   coil_release(int'(it.contactor_index));
            default:   supervise_pack(int'(it.soc), tv);
        endcase
    endtask

    function automatic status_t coil_status();
        status_t s;
        s             = '0;
        s.duty_zero   = coil_duty[0];
        s.duty_one    = coil_duty[1];
        s.duty_two    = coil_duty[2];
        s.duty_three  = coil_duty[3];
        s.charge_mode = charge_mode_q;
        for (int i = 0; i < 4; i++)
        begin
            s.on_mask[i]  = (coil_mode[i] != COIL_OFF);
            s.eco_mask[i] = (coil_mode[i] == COIL_ECON);
        end
        return s;
    endfunction

    function automatic void note_mismatch(string what, status_t want, status_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected duty %0d/%0d/%0d/%0d mode %0d on %h eco %h fill %h",
                     $realtime, what,
                     want.duty_zero, want.duty_one, want.duty_two, want.duty_three,
                     want.charge_mode, want.on_mask, want.eco_mask, want.fill);
            $display("    got duty %0d/%0d/%0d/%0d mode %0d on %h eco %h fill %h",
                     got.duty_zero, got.duty_one, got.duty_two, got.duty_three,
                     got.charge_mode, got.on_mask, got.eco_mask, got.fill);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check status beats, track settings, predict on command beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (status_due_q.size() == 0)
                    note_mismatch("status beat with nothing pending", '0, got);
                else
                begin
                    want = status_due_q.pop_front();
                    if (got.duty_zero !== want.duty_zero || got.duty_one !== want.duty_one ||
                        got.duty_two !== want.duty_two || got.duty_three !== want.duty_three ||
                        got.charge_mode !== want.charge_mode ||
                        got.on_mask !== want.on_mask || got.eco_mask !== want.eco_mask ||
                        got.fill !== want.fill)
                        note_mismatch("status beat mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_SOC_HIGH:   settings.soc_high        = cfg_data;
                    REG_SOC_MID:    settings.soc_mid         = cfg_data;
                    REG_SOC_LOW:    settings.soc_low         = cfg_data;
                    REG_SOC_HYST:   settings.soc_hysteresis  = cfg_data[9:0];
                    REG_TEMP_LIMIT: settings.temp_limit      = cfg_data[11:0];
                    REG_TEMP_HYST:  settings.temp_hysteresis = cfg_data[8:0];
                    REG_PULLIN:     settings.pullin_ticks    = cfg_data[7:0];
                    REG_ECON_DUTY:  settings.economy_duty    = cfg_data[3:0];
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_command(cur_item);
                status_due_q.push_back(cur_typed ? cur_want : coil_status());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready = 1'b0;
            stall_left    = $urandom_range(0, 14);
        end
        else
            m_axis_tready = 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(input item_t it, input bit typed, input status_t want);
        int gap;
        // hold off the sender for a random burst
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cur_item      = it;
        cur_typed     = typed;
        cur_want      = want;
        s_axis_tuser  = it.cmd;
        s_axis_tdata  = {4'b0, it.temp_three, it.temp_two, it.temp_one, it.soc,
                         it.contactor_index};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        beats_sent++;
        // stretches of back-to-back traffic
        idle_on = ((beats_sent % 96) < 64) && idle_on_allowed;
    endtask

    task automatic write_setting(input logic [2:0] index, input int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = 14'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        cfg_valid     = 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input int hi, input int mid, input int lo, input int sh,
                                 input int tl, input int th, input int pt, input int ed);
        wait_idle();
        write_setting(REG_SOC_HIGH, hi);
        write_setting(REG_SOC_MID, mid);
        write_setting(REG_SOC_LOW, lo);
        write_setting(REG_SOC_HYST, sh);
        write_setting(REG_TEMP_LIMIT, tl);
        write_setting(REG_TEMP_HYST, th);
        write_setting(REG_PULLIN, pt);
        write_setting(REG_ECON_DUTY, ed);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Charge value, mostly near one of the switching points
    function automatic int pick_soc();
        int h;
        int base;
        h = int'(settings.soc_hysteresis);
        case ($urandom_range(0, 9))
            0: base = int'(settings.soc_high);
            1: base = int'(settings.soc_mid) - h;
            2: base = int'(settings.soc_mid) + h;
            3: base = int'(settings.soc_low) - h;
            4: base = int'(settings.soc_mid);
            5: base = int'(settings.soc_low);
            6: return ($urandom_range(0, 1) == 0) ? 0 : 10000;
            default: return $urandom_range(0, 10000);
        endcase
        return clamp(base + $urandom_range(0, 8) - 4 + (($urandom_range(0, 2) == 0) ?
                     $urandom_range(0, 400) - 200 : 0), 0, 10000);
    endfunction

    // Temperature, mostly around the limit band
    function automatic int pick_temp();
        int th;
        int base;
        th = int'(settings.temp_hysteresis);
        case ($urandom_range(0, 4))
            0: base = int'(settings.temp_limit);
            1: base = int'(settings.temp_limit) + th;
            2: base = int'(settings.temp_limit) - th;
            default: return $urandom_range(0, 1900) - 400;
        endcase
        return clamp(base + $urandom_range(0, 120) - 60, -400, 1500);
    endfunction

    task automatic run_random(input int n_items, input int tick_pct);
        item_t it;
        int    r;
        int    rest;
        for (int n = 0; n < n_items; n++)
        begin
            r    = $urandom_range(0, 99);
            rest = 100 - tick_pct;
            if (r < tick_pct)
                it.cmd = CMD_TICK;
            else if (r < tick_pct + rest / 4)
                it.cmd = CMD_ON;
            else if (r < tick_pct + rest * 2 / 5)
                it.cmd = CMD_OFF;
            else
                it.cmd = CMD_SUPERVISE;
            it.contactor_index = 2'($urandom_range(0, 3));
            it.soc             = 14'(pick_soc());
            it.temp_one        = 12'(pick_temp());
            it.temp_two        = 12'(pick_temp());
            it.temp_three      = 12'(pick_temp());
            send_beat(it, 1'b0, '0);
        end
    endtask

    function automatic status_t mk_status(input int d0, input int d1, input int d2,
                                          input int d3, input logic [1:0] mode,
                                          input int on, input int eco);
        status_t s;
        s             = '0;
        s.duty_zero   = 4'(d0);
        s.duty_one    = 4'(d1);
        s.duty_two    = 4'(d2);
        s.duty_three  = 4'(d3);
        s.charge_mode = mode;
        s.on_mask     = 4'(on);
        s.eco_mask    = 4'(eco);
        return s;
    endfunction

    function automatic plan_row_t mk_row(input int reps, input logic [1:0] cmd,
                                         input logic [1:0] idx, input int soc,
                                         input int t1, input int t2, input int t3,
                                         input bit typed, input status_t want);
        plan_row_t r;
        r.reps    = reps;
        r.cmd     = cmd;
        r.idx     = idx;
        r.soc     = soc;
        r.t_one   = t1;
        r.t_two   = t2;
        r.t_three = t3;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t plan [$];
        item_t     it;
        int        s [3];
        int        tmp;

        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        m_axis_tready   = 1'b0;
        stall_left      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        beats_sent      = 0;
        idle_on_allowed = 1'b1;
        idle_on         = 1'b1;
        cur_typed       = 1'b0;
        cur_want        = '0;
        cur_item        = '0;

        // reset state of the shadow model
        for (int i = 0; i < 4; i++)
        begin
            coil_mode[i] = COIL_OFF;
            pull_cnt[i]  = 8'd0;
            coil_duty[i] = 4'd0;
        end
        charge_mode_q            = MODE_ALL_ON;
        settings.soc_high        = 14'd9900;
        settings.soc_mid         = 14'd9800;
        settings.soc_low         = 14'd9700;
        settings.soc_hysteresis  = 10'd50;
        settings.temp_limit      = 12'sd600;
        settings.temp_hysteresis = 9'd50;
        settings.pullin_ticks    = 8'd10;
        settings.economy_duty    = 4'd5;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, default settings: switch points 9900/9800/9700,
        // band 50, limit 600 with band 50, ten pull-in ticks, economy duty 5
        plan.push_back(mk_row(1, CMD_TICK, 2'd3, 0, 0, 0, 0, 1,
                              mk_status(0, 0, 0, 0, MODE_ALL_ON, 0, 0)));
        plan.push_back(mk_row(1, CMD_ON, 2'd3, 0, 0, 0, 0, 1,
                              mk_status(0, 0, 0, 10, MODE_ALL_ON, 8, 0)));
        // on command on a coil already on
        plan.push_back(mk_row(1, CMD_ON, 2'd3, 0, 0, 0, 0, 1,
                              mk_status(0, 0, 0, 10, MODE_ALL_ON, 8, 0)));
        plan.push_back(mk_row(1, CMD_OFF, 2'd3, 0, 0, 0, 0, 1,
                              mk_status(0, 0, 0, 0, MODE_ALL_ON, 0, 0)));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd1, 0, -400, -400, -400, 1,
                              mk_status(10, 10, 10, 0, MODE_ALL_ON, 7, 0)));
        plan.push_back(mk_row(9, CMD_TICK, 2'd0, 0, 0, 0, 0, 0, '0));
        // tenth tick drops the inputs to economy duty
        plan.push_back(mk_row(1, CMD_TICK, 2'd2, 0, 0, 0, 0, 1,
                              mk_status(5, 5, 5, 0, MODE_ALL_ON, 7, 7)));
        // full charge and overheat
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd0, 10000, 1500, 1500, 1500, 1,
                              mk_status(0, 0, 0, 0, MODE_ALL_OFF, 0, 0)));
        // two-on mode with fewer than two inputs on
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd0, 9749, 100, 200, 300, 0, '0));
        plan.push_back(mk_row(1, CMD_ON, 2'd0, 0, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_ON, 2'd1, 0, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_ON, 2'd2, 0, 0, 0, 0, 0, '0));
        // three on, hottest unit first in order
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9700, 300, 100, 200, 0, '0));
        // equal temperatures keep unit order
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9700, 100, 100, 100, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9700, 100, 100, 400, 0, '0));
        // coolest within the limit band, hottest above the overheat point
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9700, 560, 570, 700, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9600, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9900, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9901, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9760, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9749, 0, 0, 0, 0, '0));
        plan.push_back(mk_row(1, CMD_SUPERVISE, 2'd3, 9851, 0, 0, 0, 0, '0));

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
            begin
                it.cmd             = plan[r].cmd;
                it.contactor_index = plan[r].idx;
                it.soc             = 14'(plan[r].soc);
                it.temp_one        = 12'(plan[r].t_one);
                it.temp_two        = 12'(plan[r].t_two);
                it.temp_three      = 12'(plan[r].t_three);
                send_beat(it, plan[r].typed, plan[r].want);
            end

        // Lowest settings
        load_settings(0, 0, 0, 0, -400, 0, 1, 0);
        run_random(200, 35);

        // Highest settings, tick heavy so long pull-in completes
        load_settings(10000, 10000, 10000, 1000, 1500, 500, 255, 10);
        run_random(300, 80);

        // Random settings, the last phase without idling
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < 3; i++)
                s[i] = $urandom_range(0, 10000);
            if ($urandom_range(0, 3) != 0)
            begin
                // order the switch points the usual way
                for (int i = 0; i < 2; i++)
                    for (int j = i + 1; j < 3; j++)
                        if (s[i] > s[j])
                        begin
                            tmp  = s[i];
                            s[i] = s[j];
                            s[j] = tmp;
                        end
            end
            load_settings(s[2], s[1], s[0],
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000)
                                                      : $urandom_range(0, 200),
                          $urandom_range(0, 1900) - 400,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 500)
                                                      : $urandom_range(0, 100),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                      : $urandom_range(1, 12),
                          $urandom_range(0, 10));
            if (p == 3)
            begin
                idle_on_allowed = 1'b0;
                idle_on         = 1'b0;
            end
            run_random(250, 35);
        end

        // Drain and finish
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && status_due_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ces_pkg.sv
rtl/ces_step.sv
rtl/contactor_economizer_supervisor.sv
tb/contactor_economizer_supervisor_tb.sv
